/* rtl/sdr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types, constants and arithmetic helpers for the scatter direction
// rotation pipeline.
// ----------------------------------------------------------------------------
package sdr_pkg;

   localparam int SDR_FRAC_BITS = 30;   // default I/O fraction bits
   localparam int WORK_BITS     = 30;   // internal Q30
   localparam int CORDIC_STEPS  = 30;
   localparam int ITER_STAGES   = 31;   // square root needs 31 steps
   localparam int QBITS         = 33;   // quotient bits kept before saturation
   localparam int CORDIC_GAIN   = 652032874;

   typedef logic signed [31:0] work_type;
   typedef logic signed [33:0] rot_type;

   localparam work_type ONE_W = 32'sh4000_0000;
   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (WORK_BITS - 1);

   typedef struct packed {
      work_type          ox;
      work_type          oy;
      work_type          oz;
      work_type          mu;
      rot_type           cx;
      rot_type           cy;
      logic signed [31:0] cz;
      logic [1:0]        quad;
      logic [61:0]       sv;     // sin(theta) radicand remainder
      logic [61:0]       sres;
      logic [61:0]       fv;     // factor radicand remainder
      logic [61:0]       fres;
   } sdr_front_type;

   typedef struct packed {
      logic [63:0]      rem;
      logic [QBITS-1:0] quo;
      logic             ovf;     // quotient too large, saturate
      logic             neg;
   } sdr_lane_type;

   typedef struct packed {
      work_type           mx;
      work_type           my;
      work_type           mz;
      logic signed [32:0] nz;
      work_type           a;
      work_type           b;
      logic               fzero;
   } sdr_side_type;

   // CORDIC angle table, units of 2^-32 turn
   function automatic logic signed [31:0] turn_atan(input int i);
      logic signed [31:0] r;
      unique case (i)
         0:  r = 32'sd536870912;
         1:  r = 32'sd316933406;
         2:  r = 32'sd167458907;
         3:  r = 32'sd85004756;
         4:  r = 32'sd42667331;
         5:  r = 32'sd21354465;
         6:  r = 32'sd10679838;
         7:  r = 32'sd5340245;
         8:  r = 32'sd2670163;
         9:  r = 32'sd1335087;
         10: r = 32'sd667544;
         11: r = 32'sd333772;
         12: r = 32'sd166886;
         13: r = 32'sd83443;
         14: r = 32'sd41722;
         15: r = 32'sd20861;
         16: r = 32'sd10430;
         17: r = 32'sd5215;
         18: r = 32'sd2608;
         19: r = 32'sd1304;
         20: r = 32'sd652;
         21: r = 32'sd326;
         22: r = 32'sd163;
         23: r = 32'sd81;
         24: r = 32'sd41;
         25: r = 32'sd20;
         26: r = 32'sd10;
         27: r = 32'sd5;
         28: r = 32'sd3;
         29: r = 32'sd1;
         default: r = 32'sd0;
      endcase
      return r;
   endfunction

   // rounded Q30 product
   function automatic work_type mulr(input work_type a, input work_type b);
      logic signed [63:0] p;
      p = a * b + ROUND_HALF;
      return p[WORK_BITS+31:WORK_BITS];
   endfunction

endpackage

/* rtl/sdr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_front
// Pipelined CORDIC (azimuth cos/sin) running beside two pipelined integer
// square roots (sin theta and the rotation factor), one step per stage.
// ----------------------------------------------------------------------------
module sdr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  sdr_pkg::sdr_front_type in_data,
   output logic                  out_valid,
   output sdr_pkg::sdr_front_type out_data
);
   import sdr_pkg::*;

   logic [ITER_STAGES-1:0] valid_ff;
   sdr_front_type          data_ff [ITER_STAGES];
   sdr_front_type          data_in [ITER_STAGES];

   function automatic sdr_front_type iter_step(input sdr_front_type d, input int k);
      sdr_front_type r;
      logic [61:0]   bit_v;
      r     = d;
      bit_v = 62'(1) << (60 - 2 * k);
      if (k < CORDIC_STEPS) begin
         if (!d.cz[31]) begin
            r.cx = d.cx - (d.cy >>> k);
            r.cy = d.cy + (d.cx >>> k);
            r.cz = d.cz - turn_atan(k);
         end else begin
            r.cx = d.cx + (d.cy >>> k);
            r.cy = d.cy - (d.cx >>> k);
            r.cz = d.cz + turn_atan(k);
         end
      end
      if (d.sv >= d.sres + bit_v) begin
         r.sv   = d.sv - (d.sres + bit_v);
         r.sres = (d.sres >> 1) + bit_v;
      end else begin
         r.sres = d.sres >> 1;
      end
      if (d.fv >= d.fres + bit_v) begin
         r.fv   = d.fv - (d.fres + bit_v);
         r.fres = (d.fres >> 1) + bit_v;
      end else begin
         r.fres = d.fres >> 1;
      end
      return r;
   endfunction

   always_comb begin
      data_in[0] = iter_step(in_data, 0);
      for (int k = 1; k < ITER_STAGES; k++) begin
         data_in[k] = iter_step(data_ff[k-1], k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[ITER_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < ITER_STAGES; k++) begin
            data_ff[k] <= data_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ITER_STAGES-1];
   assign out_data  = data_ff[ITER_STAGES-1];

`ifndef NO_ASSERTIONS
   a_sqrt_range: assert property (@(posedge clock)
      out_valid |-> (out_data.sres <= (62'(1) << WORK_BITS)))
      else $error("square root above one");
   a_cordic_converged: assert property (@(posedge clock)
      out_valid |-> (out_data.cz < 32'sd64 && out_data.cz > -32'sd64))
      else $error("CORDIC residual angle too large");
   a_reset_clear: assert property (@(posedge clock) reset |=> !out_valid)
      else $error("valid survived reset");
`endif

endmodule

/* rtl/sdr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_div
// Two-lane pipelined restoring divider, one quotient bit per stage, with
// side data carried alongside each item.
// ----------------------------------------------------------------------------
module sdr_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  sdr_pkg::sdr_lane_type in_x,
   input  sdr_pkg::sdr_lane_type in_y,
   input  logic [30:0]          in_den,
   input  sdr_pkg::sdr_side_type in_side,
   output logic                 out_valid,
   output sdr_pkg::sdr_lane_type out_x,
   output sdr_pkg::sdr_lane_type out_y,
   output sdr_pkg::sdr_side_type out_side
);
   import sdr_pkg::*;

   logic [QBITS-1:0] valid_ff;
   sdr_lane_type     x_ff [QBITS];
   sdr_lane_type     y_ff [QBITS];
   sdr_lane_type     x_in [QBITS];
   sdr_lane_type     y_in [QBITS];
   logic [30:0]      den_ff [QBITS];
   sdr_side_type     side_ff [QBITS];

   function automatic sdr_lane_type div_step(input sdr_lane_type l,
                                             input logic [30:0] den, input int j);
      sdr_lane_type r;
      logic [63:0]  sh;
      r  = l;
      sh = 64'(den) << j;
      if (!l.ovf && l.rem >= sh) begin
         r.rem    = l.rem - sh;
         r.quo[j] = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      x_in[0] = div_step(in_x, in_den, QBITS - 1);
      y_in[0] = div_step(in_y, in_den, QBITS - 1);
      for (int k = 1; k < QBITS; k++) begin
         x_in[k] = div_step(x_ff[k-1], den_ff[k-1], QBITS - 1 - k);
         y_in[k] = div_step(y_ff[k-1], den_ff[k-1], QBITS - 1 - k);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QBITS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 0; k < QBITS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
         end
         for (int k = 1; k < QBITS; k++) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QBITS-1];
   assign out_x     = x_ff[QBITS-1];
   assign out_y     = y_ff[QBITS-1];
   assign out_side  = side_ff[QBITS-1];

`ifndef NO_ASSERTIONS
   a_rem_x: assert property (@(posedge clock)
      out_valid && !out_x.ovf |-> (out_x.rem < 64'(den_ff[QBITS-1])))
      else $error("x remainder not below divisor");
   a_rem_y: assert property (@(posedge clock)
      out_valid && !out_y.ovf |-> (out_y.rem < 64'(den_ff[QBITS-1])))
      else $error("y remainder not below divisor");
   a_reset_clear: assert property (@(posedge clock) reset |=> !out_valid)
      else $error("valid survived reset");
`endif

endmodule

/* rtl/scatter_direction_rotation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_direction_rotation
// Rotates a unit direction by a scattering cosine and an azimuth.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item holds old_x, old_y, old_z, scatter_cosine (signed
//   Q(FRAC_BITS)) and azimuth (unsigned, fraction of a turn).
//   rsp channel: one item per request with new_x, new_y, new_z, saturated
//   to +-1 (and to the 32-bit range for wide formats).
//   The pipeline has 2 input stages, 31 CORDIC / square root steps, 6 multiply
//   and prepare stages, 33 divider stages (one quotient bit each) and the
//   output register. Throughput is one item per cycle while the receiver does
//   not stall; every stage holds one item.
//   A stalled receiver freezes the whole pipeline: req_tready follows
//   "output register empty or being taken", so nothing is lost or repeated.
//   Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module scatter_direction_rotation #(
   parameter int FRAC_BITS = sdr_pkg::SDR_FRAC_BITS   // 14 .. 62
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // old_x[31:0], old_y[63:32], old_z[95:64], scatter_cosine[127:96],
   // azimuth[159:128]
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_x[31:0], new_y[63:32], new_z[95:64]
   output logic [95:0]  rsp_tdata
);
   import sdr_pkg::*;

   localparam int UP_SH = (FRAC_BITS >= WORK_BITS) ? FRAC_BITS - WORK_BITS : 0;
   localparam int DN_SH = (FRAC_BITS <  WORK_BITS) ? WORK_BITS - FRAC_BITS : 0;

   function automatic work_type to_work(input logic [31:0] raw);
      logic signed [63:0] v;
      logic signed [63:0] one_io;
      one_io = 64'sd1 <<< FRAC_BITS;
      v      = $signed(raw);
      if (v > one_io) v = one_io;
      else if (v < -one_io) v = -one_io;
      if (FRAC_BITS >= WORK_BITS) v = v >>> UP_SH;
      else v = v <<< DN_SH;
      return v[31:0];
   endfunction

   function automatic logic [31:0] from_work(input work_type r);
      logic signed [63:0] v;
      v = r;
      if (FRAC_BITS >= WORK_BITS) v = v <<< UP_SH;
      else v = v >>> DN_SH;
      if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      else if (v < -64'sh8000_0000) v = -64'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic work_type clamp_rot(input rot_type v);
      work_type r;
      if (v > rot_type'(ONE_W)) r = ONE_W;
      else if (v < -rot_type'(ONE_W)) r = -ONE_W;
      else r = v[31:0];
      return r;
   endfunction

   function automatic work_type clamp33(input logic signed [32:0] v);
      work_type r;
      if (v > 33'(ONE_W)) r = ONE_W;
      else if (v < -33'(ONE_W)) r = -ONE_W;
      else r = v[31:0];
      return r;
   endfunction

   // signed quotient plus the direct term, clamped to +-1
   function automatic work_type finish(input sdr_lane_type l, input work_type base);
      logic [QBITS-1:0]       q;
      logic signed [QBITS+1:0] sq;
      logic signed [QBITS+1:0] sum;
      work_type               r;
      q   = l.ovf ? '1 : l.quo;
      sq  = $signed({2'b00, q});
      if (l.neg) sq = -sq;
      sum = sq + base;
      if (sum > (QBITS+2)'(ONE_W)) r = ONE_W;
      else if (sum < -(QBITS+2)'(ONE_W)) r = -ONE_W;
      else r = sum[31:0];
      return r;
   endfunction

   function automatic sdr_lane_type lane_init(input logic signed [63:0] num,
                                              input logic [30:0] den);
      sdr_lane_type l;
      logic [63:0]  half;
      half  = 64'(den >> 1);
      l.neg = num[63];
      l.rem = l.neg ? (~num + half + 64'd1) : (num + half);
      l.ovf = (l.rem >> QBITS) >= 64'(den);
      l.quo = '0;
      return l;
   endfunction

   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // stage 0: clamp and convert
   logic     s0_v_ff;
   work_type s0_ox_ff, s0_oy_ff, s0_oz_ff, s0_mu_ff;
   logic [31:0] s0_ang_ff;

   // stage 1: squares, angle reduction
   logic        s1_v_ff;
   work_type    s1_ox_ff, s1_oy_ff, s1_oz_ff, s1_mu_ff;
   logic [61:0] s1_sv_ff, s1_fv_ff;
   logic [1:0]  s1_quad_ff;
   logic signed [31:0] s1_cz_ff;
   logic signed [63:0] mu_sq_in, oz_sq_in;
   logic [31:0]        turn_in;

   sdr_front_type front_in;
   sdr_front_type front_out;
   logic          front_v;

   // stage 2..7
   logic        s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   work_type    s2_cp_ff, s2_sp_ff, s2_st_ff;
   work_type    s2_ox_ff, s2_oy_ff, s2_oz_ff, s2_mu_ff;
   logic [30:0] s2_fac_ff, s3_fac_ff, s4_fac_ff, s5_fac_ff, s6_fac_ff;
   work_type    cp_in, sp_in, cx_in, cy_in;
   work_type    s3_a_ff, s3_b_ff, s3_ox_ff, s3_oy_ff, s3_oz_ff, s3_mu_ff;
   work_type    s4_tz_ff, s4_mx_ff, s4_my_ff, s4_mz_ff, s4_fa_ff;
   work_type    s4_ox_ff, s4_oy_ff, s4_a_ff, s4_b_ff;
   logic signed [63:0] s5_px1_ff, s5_px2_ff, s5_py1_ff, s5_py2_ff;
   work_type    s5_mx_ff, s5_my_ff, s5_mz_ff, s5_fa_ff, s5_a_ff, s5_b_ff;
   logic signed [63:0] s6_numx_ff, s6_numy_ff;
   logic signed [32:0] s6_nz_ff;
   work_type    s6_mx_ff, s6_my_ff, s6_mz_ff, s6_a_ff, s6_b_ff;
   sdr_lane_type s7_x_ff, s7_y_ff;
   logic [30:0]  s7_den_ff;
   sdr_side_type s7_side_ff;

   logic         div_v;
   sdr_lane_type div_x, div_y;
   sdr_side_type div_side;

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff;
   work_type    nx_in, ny_in, nz_in;

   assign mu_sq_in = s0_mu_ff * s0_mu_ff;
   assign oz_sq_in = s0_oz_ff * s0_oz_ff;
   assign turn_in  = s0_ang_ff + 32'h2000_0000;

   always_comb begin
      front_in.ox   = s1_ox_ff;
      front_in.oy   = s1_oy_ff;
      front_in.oz   = s1_oz_ff;
      front_in.mu   = s1_mu_ff;
      front_in.cx   = rot_type'(CORDIC_GAIN);
      front_in.cy   = '0;
      front_in.cz   = s1_cz_ff;
      front_in.quad = s1_quad_ff;
      front_in.sv   = s1_sv_ff;
      front_in.sres = '0;
      front_in.fv   = s1_fv_ff;
      front_in.fres = '0;
   end

   sdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s1_v_ff),
      .in_data   (front_in),
      .out_valid (front_v),
      .out_data  (front_out)
   );

   // quadrant fold of the clamped CORDIC outputs
   always_comb begin
      cx_in = clamp_rot(front_out.cx);
      cy_in = clamp_rot(front_out.cy);
      unique case (front_out.quad)
         2'd0: begin cp_in = cx_in;  sp_in = cy_in;  end
         2'd1: begin cp_in = -cy_in; sp_in = cx_in;  end
         2'd2: begin cp_in = -cx_in; sp_in = -cy_in; end
         2'd3: begin cp_in = cy_in;  sp_in = -cx_in; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff       <= 1'b0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         s3_v_ff       <= 1'b0;
         s4_v_ff       <= 1'b0;
         s5_v_ff       <= 1'b0;
         s6_v_ff       <= 1'b0;
         s7_v_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff       <= req_tvalid;
         s1_v_ff       <= s0_v_ff;
         s2_v_ff       <= front_v;
         s3_v_ff       <= s2_v_ff;
         s4_v_ff       <= s3_v_ff;
         s5_v_ff       <= s4_v_ff;
         s6_v_ff       <= s5_v_ff;
         s7_v_ff       <= s6_v_ff;
         rsp_tvalid_ff <= div_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ox_ff   <= to_work(req_tdata[31:0]);
         s0_oy_ff   <= to_work(req_tdata[63:32]);
         s0_oz_ff   <= to_work(req_tdata[95:64]);
         s0_mu_ff   <= to_work(req_tdata[127:96]);
         s0_ang_ff  <= req_tdata[159:128];

         s1_ox_ff   <= s0_ox_ff;
         s1_oy_ff   <= s0_oy_ff;
         s1_oz_ff   <= s0_oz_ff;
         s1_mu_ff   <= s0_mu_ff;
         s1_sv_ff   <= 62'((64'sd1 <<< (2 * WORK_BITS)) - mu_sq_in);
         s1_fv_ff   <= 62'((64'sd1 <<< (2 * WORK_BITS)) - oz_sq_in);
         s1_quad_ff <= turn_in[31:30];
         s1_cz_ff   <= $signed({2'b00, turn_in[29:0]}) - 32'sh2000_0000;

         s2_cp_ff   <= cp_in;
         s2_sp_ff   <= sp_in;
         s2_st_ff   <= $signed({1'b0, front_out.sres[30:0]});
         s2_fac_ff  <= front_out.fres[30:0];
         s2_ox_ff   <= front_out.ox;
         s2_oy_ff   <= front_out.oy;
         s2_oz_ff   <= front_out.oz;
         s2_mu_ff   <= front_out.mu;

         s3_a_ff    <= mulr(s2_st_ff, s2_cp_ff);
         s3_b_ff    <= mulr(s2_st_ff, s2_sp_ff);
         s3_fac_ff  <= s2_fac_ff;
         s3_ox_ff   <= s2_ox_ff;
         s3_oy_ff   <= s2_oy_ff;
         s3_oz_ff   <= s2_oz_ff;
         s3_mu_ff   <= s2_mu_ff;

         s4_tz_ff   <= mulr(s3_oz_ff, s3_a_ff);
         s4_mx_ff   <= mulr(s3_ox_ff, s3_mu_ff);
         s4_my_ff   <= mulr(s3_oy_ff, s3_mu_ff);
         s4_mz_ff   <= mulr(s3_oz_ff, s3_mu_ff);
         s4_fa_ff   <= mulr($signed({1'b0, s3_fac_ff}), s3_a_ff);
         s4_ox_ff   <= s3_ox_ff;
         s4_oy_ff   <= s3_oy_ff;
         s4_a_ff    <= s3_a_ff;
         s4_b_ff    <= s3_b_ff;
         s4_fac_ff  <= s3_fac_ff;

         s5_px1_ff  <= s4_ox_ff * s4_tz_ff;
         s5_px2_ff  <= s4_oy_ff * s4_b_ff;
         s5_py1_ff  <= s4_oy_ff * s4_tz_ff;
         s5_py2_ff  <= s4_ox_ff * s4_b_ff;
         s5_mx_ff   <= s4_mx_ff;
         s5_my_ff   <= s4_my_ff;
         s5_mz_ff   <= s4_mz_ff;
         s5_fa_ff   <= s4_fa_ff;
         s5_a_ff    <= s4_a_ff;
         s5_b_ff    <= s4_b_ff;
         s5_fac_ff  <= s4_fac_ff;

         s6_numx_ff <= s5_px1_ff - s5_px2_ff;
         s6_numy_ff <= s5_py1_ff + s5_py2_ff;
         s6_nz_ff   <= 33'(s5_mz_ff) - 33'(s5_fa_ff);
         s6_mx_ff   <= s5_mx_ff;
         s6_my_ff   <= s5_my_ff;
         s6_mz_ff   <= s5_mz_ff;
         s6_a_ff    <= s5_a_ff;
         s6_b_ff    <= s5_b_ff;
         s6_fac_ff  <= s5_fac_ff;

         s7_x_ff          <= lane_init(s6_numx_ff, s6_fac_ff);
         s7_y_ff          <= lane_init(s6_numy_ff, s6_fac_ff);
         s7_den_ff        <= s6_fac_ff;
         s7_side_ff.mx    <= s6_mx_ff;
         s7_side_ff.my    <= s6_my_ff;
         s7_side_ff.mz    <= s6_mz_ff;
         s7_side_ff.nz    <= s6_nz_ff;
         s7_side_ff.a     <= s6_a_ff;
         s7_side_ff.b     <= s6_b_ff;
         s7_side_ff.fzero <= (s6_fac_ff == '0);

         rsp_tdata_ff <= {from_work(nz_in), from_work(ny_in), from_work(nx_in)};
      end
   end

   sdr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s7_v_ff),
      .in_x      (s7_x_ff),
      .in_y      (s7_y_ff),
      .in_den    (s7_den_ff),
      .in_side   (s7_side_ff),
      .out_valid (div_v),
      .out_x     (div_x),
      .out_y     (div_y),
      .out_side  (div_side)
   );

   // pole case: old direction along z uses the plain form
   always_comb begin
      if (div_side.fzero) begin
         nx_in = div_side.a;
         ny_in = div_side.b;
         nz_in = div_side.mz;
      end else begin
         nx_in = finish(div_x, div_side.mx);
         ny_in = finish(div_y, div_side.my);
         nz_in = clamp33(div_side.nz);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid survived reset");
   a_pole_factor: assert property (@(posedge clock)
      s7_v_ff && s7_side_ff.fzero |-> s7_x_ff.ovf && s7_y_ff.ovf)
      else $error("zero factor not flagged as saturated division");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s7_v_ff) && $stable(s2_v_ff) && $stable(s0_v_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for scatter_direction_rotation. A table of directed
// items (poles, axes, clamped inputs, quadrant edges) is followed by random
// directions, partly unit length and partly raw noise. Every result is checked
// field by field against a bit-exact model or typed-in value. Both sides idle
// at random in three phases; one long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
   localparam int FB = sdr_pkg::SDR_FRAC_BITS;
   localparam longint ONE = 64'sd1 << 30;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM = 1230;

   typedef struct packed {
      logic [31:0] az;
      logic [31:0] mu;
      logic [31:0] oz;
      logic [31:0] oy;
      logic [31:0] ox;
   } dir_item_type;

   typedef struct {
      dir_item_type item;
      logic         fixed;   // expected typed in
      logic [95:0]  dir_out;
   } dir_row_type;

   logic clock = 1'b0, reset = 1'b1;
   logic req_tvalid = 1'b0, req_tready, rsp_tvalid, rsp_tready = 1'b0;
   logic [159:0] req_tdata = '0;
   logic [95:0] rsp_tdata;

   scatter_direction_rotation dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [95:0] expected_dirs[$];
   int errors = 0, n_sent = 0, n_got = 0, idle_cycles = 0;
   int src_idle = 19, snk_idle = 56;
   bit hold_sink = 1'b0;
   longint atan_tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint root60(longint v);
      longint unsigned r, bt, x;
      x = v; r = 0; bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint qdiv(longint num, longint den);
      longint unsigned m, q;
      m = num < 0 ? -num : num;
      q = (m + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint to_q30(logic [31:0] raw);
      longint v;
      v = clip(longint'($signed(raw)), -(64'sd1 << FB), 64'sd1 << FB);
      return FB >= 30 ? v >>> (FB - 30) : v * (64'sd1 << (30 - FB));
   endfunction

   function automatic logic [31:0] from_q30(longint r);
      longint v;
      r = clip(r, -ONE, ONE);
      v = FB >= 30 ? r * (64'sd1 << (FB - 30)) : r >>> (30 - FB);
      v = clip(v, -64'sd2147483648, 64'sd2147483647);
      return v[31:0];
   endfunction

   // predicted new direction for one item
   function automatic logic [95:0] rotate_dir(dir_item_type it);
      longint ox, oy, oz, mu, x, y, z, nx, cp, sp, st, fac, a, b, tz, rx, ry, rz;
      logic [31:0] t;
      ox = to_q30(it.ox); oy = to_q30(it.oy); oz = to_q30(it.oz); mu = to_q30(it.mu);
      t = it.az + 32'h2000_0000;
      z = longint'(t[29:0]) - 64'sd536870912;
      x = 652032874; y = 0;
      for (int i = 0; i < 30; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
         end else begin
            nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
         end
         x = nx;
      end
      x = clip(x, -ONE, ONE); y = clip(y, -ONE, ONE);
      case (t[31:30])
         2'd0: begin cp = x;  sp = y;  end
         2'd1: begin cp = -y; sp = x;  end
         2'd2: begin cp = -x; sp = -y; end
         default: begin cp = y; sp = -x; end
      endcase
      st = root60((ONE * ONE) - mu * mu);
      fac = root60((ONE * ONE) - oz * oz);
      a = qmul(st, cp); b = qmul(st, sp);
      if (fac == 0) begin
         rx = a; ry = b; rz = qmul(oz, mu);
      end else begin
         tz = qmul(oz, a);
         rx = qmul(ox, mu) + qdiv(ox * tz - oy * b, fac);
         ry = qmul(oy, mu) + qdiv(oy * tz + ox * b, fac);
         rz = qmul(oz, mu) - qmul(fac, a);
      end
      return {from_q30(rz), from_q30(ry), from_q30(rx)};
   endfunction

   function automatic logic [31:0] rnd_cos();
      case ($urandom_range(0, 9))
         0: return $urandom();                       // full raw range
         1: return $urandom_range(0, 1) ? 32'h4000_0000 : 32'hC000_0000;
         default: return 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
      endcase
   endfunction

   // random direction: mostly unit length via a rotation of the z pole
   function automatic dir_item_type rnd_item();
      dir_item_type it;
      logic [95:0] d;
      it.mu = rnd_cos(); it.az = $urandom();
      if ($urandom_range(0, 3) == 0) begin
         it.ox = rnd_cos(); it.oy = rnd_cos(); it.oz = rnd_cos();
      end else begin
         d = rotate_dir('{az: $urandom(), mu: rnd_cos(), oz: 32'h4000_0000,
                          oy: 32'h0, ox: 32'h0});
         {it.oz, it.oy, it.ox} = d;
      end
      return it;
   endfunction

   // leaves req_tvalid high; it drops only while idling or after the last item
   task automatic send_item(dir_item_type it);
      while ($urandom_range(0, 99) < src_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= it;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_dirs.push_back(rotate_dir(it));
      n_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && !hold_sink)
         rsp_tready <= ($urandom_range(0, 99) >= snk_idle);
      else
         rsp_tready <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_dirs.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            logic [95:0] e;
            e = expected_dirs.pop_front();
            for (int f = 0; f < 3; f++)
               if (e[32*f +: 32] !== rsp_tdata[32*f +: 32]) begin
                  $display("%0t: new_%s expected %h actual %h", $time,
                           f == 0 ? "x" : f == 1 ? "y" : "z",
                           e[32*f +: 32], rsp_tdata[32*f +: 32]);
                  errors++;
               end
         end
         n_got++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog, no progress", $time);
         $display("simulation failed");
         $finish;
      end
   end

   dir_row_type rows[$];

   task automatic add_row(logic [31:0] ox, oy, oz, mu, az, logic fx = 0,
                          logic [95:0] res = '0);
      dir_row_type r;
      r.item = '{az: az, mu: mu, oz: oz, oy: oy, ox: ox};
      r.fixed = fx; r.dir_out = res;
      rows.push_back(r);
   endtask

   initial begin
      // poles with forward/backward scatter read off directly
      add_row(0, 0, 32'h4000_0000, 32'h4000_0000, 0, 1, {32'h4000_0000, 64'h0});
      add_row(0, 0, 32'h4000_0000, 32'hC000_0000, 0, 1, {32'hC000_0000, 64'h0});
      add_row(0, 0, 32'hC000_0000, 32'h4000_0000, 0, 1, {32'hC000_0000, 64'h0});
      add_row(0, 0, 32'hC000_0000, 32'hC000_0000, 32'h8000_0000, 1, {32'h4000_0000, 64'h0});
      // pole, perpendicular scatter, quadrant edges of the azimuth
      add_row(0, 0, 32'h4000_0000, 0, 32'h0000_0000);
      add_row(0, 0, 32'h4000_0000, 0, 32'h4000_0000);
      add_row(0, 0, 32'hC000_0000, 0, 32'h8000_0000);
      add_row(0, 0, 32'h4000_0000, 0, 32'hC000_0000);
      add_row(0, 0, 32'h4000_0000, 0, 32'hFFFF_FFFF);
      add_row(0, 0, 32'h4000_0000, 0, 32'h2000_0000);
      // clamped inputs beyond one
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1234_5678);
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hDEAD_BEEF);
      // equator axes
      add_row(32'h4000_0000, 0, 0, 0, 32'h4000_0000);
      add_row(0, 32'h4000_0000, 0, 32'h2000_0000, 32'h6000_0000);
      add_row(32'hC000_0000, 0, 0, 32'hE000_0000, 32'hA000_0000);
      // nearly along z: tiny factor, huge quotient saturates
      add_row(32'h4000_0000, 32'h4000_0000, 32'h3FFF_FFFF, 0, 32'h1000_0000);
      add_row(32'hC000_0000, 32'h4000_0000, 32'hC000_0001, 32'h0000_0001, 32'h5555_5555);
      // not a unit vector, all zero, then an equator diagonal
      add_row(0, 0, 0, 0, 0);
      add_row(32'h2D41_3CCD, 32'h2D41_3CCD, 0, 32'hFFFF_FFFF, 32'h8000_0001);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < rows.size(); i++) begin
         send_item(rows[i].item);
         if (rows[i].fixed) expected_dirs[$] = rows[i].dir_out;
      end

      // phase 1 with a long hold-off so the pipeline backs up
      fork
         begin
            hold_sink = 1'b1;
            repeat (300) @(posedge clock);
            hold_sink = 1'b0;
         end
         for (int i = 0; i < N_RANDOM / 3; i++) send_item(rnd_item());
      join
      src_idle = 56; snk_idle = 19;
      for (int i = 0; i < N_RANDOM / 3; i++) send_item(rnd_item());
      src_idle = 0; snk_idle = 0;
      for (int i = 0; i < N_RANDOM - 2 * (N_RANDOM / 3); i++) send_item(rnd_item());
      req_tvalid <= 1'b0;

      while (expected_dirs.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d directions (%0d directed), checked %0d rotations, %0d errors",
               n_sent, rows.size(), n_got, errors);
      $display("covered poles, clamping, near-pole saturation and random unit vectors");
      if (errors == 0 && expected_dirs.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
